[src/ddarc_pkg.sv]
// ddarc_pkg: shared types, constants and command/status structs
// for the dda grid ray caster; no dependencies
package ddarc_pkg;

  localparam int MapLog2   = 6;
  localparam int MapN      = 1 << MapLog2;
  localparam int FracBits  = 10;
  localparam int AddrW     = 2 * MapLog2;
  localparam int DistW     = 32;
  localparam int PerpW     = 17;
  localparam int HalfW     = 21;
  localparam int CfgIdxW   = 1;
  localparam int InDataW   = 96;
  localparam int OutDataW  = 56;

  localparam logic [CfgIdxW-1:0] RegScreenHeight = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWallScale    = 1'b1;

  localparam logic [DistW-1:0] DistMax  = '1;
  localparam logic [PerpW-1:0] PerpMax  = '1;
  localparam logic [HalfW-1:0] HalfMax  = 21'h100000;
  localparam logic [MapLog2-1:0] MapMask = '1;

  typedef struct packed {
    logic load;       // latch ray inputs
    logic div_start;  // start a division
    logic div_sel_y;  // divisor: 0 cos, 1 sin
    logic div_half;   // divide for half height
    logic store_dx;
    logic store_dy;
    logic init_side;  // form first side distances
    logic step;       // one dda step
    logic perp;       // compute corrected distance
    logic finish;     // form wall rows
  } ddarc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;       // ray reached stop or border
  } ddarc_sts_t;

endpackage

[src/dda_grid_ray_caster.sv]
// dda_grid_ray_caster: top level, stream ports, config registers, output stage
// depends on ddarc_pkg, ddarc_ctrl, ddarc_dp
//
// channel | dir | fields
// in_     | in  | op, cell, position, trig, correction
// out_    | out | hit cell, side, distance, wall rows
// cfg_    | in  | register index and value
//
// map write: written as the request is taken. ray: the two reciprocals and the
// half-height division (one bit a cycle) plus a move and a map read per grid step.
// after reset a clearing pass over all 4096 map cells runs before input is taken.
// a result held at the output stalls the next ray at its end only.
module dda_grid_ray_caster
  import ddarc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,  // op, cell_x, cell_y, cell_stop, pos_x, pos_y,
                                         // ray_cos, ray_sin, view_correction, zero pad
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata, // hit_x, hit_y, hit_side, perp_distance,
                                         // wall_top, wall_bottom, zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [10:0]         cfg_data
);

  logic [10:0] screen_height_r, wall_scale_r;
  ddarc_cmd_t cmd;
  ddarc_sts_t sts;
  logic busy, done, clr_busy, acc, out_valid_r, out_busy;
  logic [55:0] result;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= 11'd512;
      wall_scale_r    <= 11'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegScreenHeight: screen_height_r <= cfg_data;
        RegWallScale:    wall_scale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !busy && !clr_busy;
  assign acc = in_tvalid && in_tready;
  assign out_busy = out_valid_r && !out_tready;

  ddarc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc && in_tdata[0]), .out_busy(out_busy),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  ddarc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .map_we(acc && !in_tdata[0]),
    .map_waddr({in_tdata[12:7], in_tdata[6:1]}),
    .map_wdata(in_tdata[13]), .clr_busy(clr_busy),
    .pos_x(in_tdata[29:14]), .pos_y(in_tdata[45:30]),
    .ray_cos(in_tdata[61:46]), .ray_sin(in_tdata[77:62]),
    .view_correction(in_tdata[92:78]),
    .screen_height(screen_height_r), .wall_scale(wall_scale_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result;

endmodule

[src/ddarc_ctrl.sv]
// ddarc_ctrl: controller state machine sequencing one ray cast
// depends on ddarc_pkg
module ddarc_ctrl
  import ddarc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       out_busy,
  input  ddarc_sts_t sts,
  output ddarc_cmd_t cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DXGO  = 10'b0000000010,
    S_DXW   = 10'b0000000100,
    S_DYGO  = 10'b0000001000,
    S_DYW   = 10'b0000010000,
    S_INIT  = 10'b0000100000,
    S_STEP  = 10'b0001000000,
    S_PERP  = 10'b0010000000,
    S_HW    = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DXGO;
        end
      end
      S_DXGO: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DXW;
      end
      S_DXW: begin
        if (sts.div_done) begin
          cmd.store_dx = 1'b1;
          state_nxt = S_DYGO;
        end
      end
      S_DYGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt = S_DYW;
      end
      S_DYW: begin
        cmd.div_sel_y = 1'b1;
        if (sts.div_done) begin
          cmd.store_dy = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_side = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.stop) state_nxt = S_PERP;
      end
      S_PERP: begin
        cmd.perp = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_half = 1'b1;
        state_nxt = S_HW;
      end
      S_HW: begin
        cmd.div_half = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[src/ddarc_div.sv]
// ddarc_div: radix-2 restoring divider, one quotient bit a cycle
// depends on ddarc_pkg
module ddarc_div
  import ddarc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [17:0] divisor,
  output logic [31:0] quot,
  output logic        done
);

  logic [31:0] q_r, q_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [17:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r;
  logic [18:0] trial;
  logic [19:0] sub;

  always_comb begin
    trial   = {rem_r[17:0], q_r[31]};
    sub     = {1'b0, trial} - {2'b00, dvs_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (run_r) begin
      if (!sub[19]) begin
        rem_nxt = sub[18:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= 6'd32;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // quotient is complete the cycle after the last bit
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= run_r && (cnt_r == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

[src/ddarc_dp.sv]
// ddarc_dp: datapath with wall map, side distances, dda stepping and
// projection; depends on ddarc_pkg and ddarc_div
module ddarc_dp
  import ddarc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ddarc_cmd_t          cmd,
  output ddarc_sts_t          sts,
  input  logic                map_we,
  input  logic [AddrW-1:0]    map_waddr,
  input  logic                map_wdata,
  output logic                clr_busy,
  input  logic [15:0]         pos_x,
  input  logic [15:0]         pos_y,
  input  logic signed [15:0]  ray_cos,
  input  logic signed [15:0]  ray_sin,
  input  logic [14:0]         view_correction,
  input  logic [10:0]         screen_height,
  input  logic [10:0]         wall_scale,
  output logic [55:0]         result
);

  logic wall_mem [MapN*MapN];
  logic [AddrW-1:0] clr_addr_r;
  logic             clr_r;

  logic [15:0] px_r, py_r;
  logic [16:0] mcos_r, msin_r;
  logic        negx_r, negy_r;
  logic [14:0] corr_r;
  logic [MapLog2-1:0] mx_r, my_r;
  logic [DistW-1:0] dx_r, dy_r, sx_r, sy_r, dist_r;
  logic        side_r;
  logic [PerpW-1:0] perp_r;
  logic        look_r;   // a step was taken, map read pending
  logic        stop_r;

  logic [31:0] div_q;
  logic        div_done;
  logic [31:0] div_a;
  logic [17:0] div_b;
  logic [16:0] mag;

  logic [46:0]      pprod;
  logic [PerpW-1:0] perp_sat;
  assign pprod    = dist_r * corr_r;
  assign perp_sat = (pprod[46:31] != '0) ? PerpMax : pprod[30:14];

  assign mag = cmd.div_sel_y ? msin_r : mcos_r;

  always_comb begin
    if (cmd.div_half) begin
      div_a = {11'd0, wall_scale, 10'd0};
      div_b = {perp_sat, 1'b0};
    end else begin
      div_a = 32'h0100_0000;
      div_b = {1'b0, mag};
    end
  end

  ddarc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(div_a), .divisor(div_b), .quot(div_q), .done(div_done)
  );

  // wall map clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) clr_r <= 1'b0;
    end
  end
  assign clr_busy = clr_r;

  logic [MapLog2-1:0] nmx, nmy;
  logic             xstep, border;
  logic [32:0]      sadd;
  logic [DistW-1:0] sadd_sat;

  always_comb begin
    xstep  = sx_r < sy_r;
    nmx    = negx_r ? mx_r - 1'b1 : mx_r + 1'b1;
    nmy    = negy_r ? my_r - 1'b1 : my_r + 1'b1;
    border = xstep ? (negx_r ? mx_r == '0 : mx_r == MapMask)
                   : (negy_r ? my_r == '0 : my_r == MapMask);
    sadd   = xstep ? {1'b0, sx_r} + {1'b0, dx_r} : {1'b0, sy_r} + {1'b0, dy_r};
    sadd_sat = sadd[32] ? DistMax : sadd[31:0];
  end

  // map read is registered: the cell entered by a move is read at the move edge
  logic [MapLog2-1:0] rmx, rmy;
  logic               rd_cell;
  assign rmx = xstep ? nmx : mx_r;
  assign rmy = xstep ? my_r : nmy;

  always_ff @(posedge clk) begin
    if (clr_r) wall_mem[clr_addr_r] <= 1'b0;
    else if (map_we) wall_mem[map_waddr] <= map_wdata;
    rd_cell <= wall_mem[{rmy, rmx}];
  end

  // first side distance multiply
  logic [10:0] fx, fy;
  logic [42:0] fpx, fpy;
  always_comb begin
    fx  = negx_r ? {1'b0, px_r[9:0]} : 11'd1024 - {1'b0, px_r[9:0]};
    fy  = negy_r ? {1'b0, py_r[9:0]} : 11'd1024 - {1'b0, py_r[9:0]};
    fpx = (fx * dx_r) >> FracBits;
    fpy = (fy * dy_r) >> FracBits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r <= 1'b0;
      stop_r <= 1'b0;
    end else if (cmd.init_side) begin
      look_r <= 1'b0;
      stop_r <= 1'b0;
    end else if (cmd.step) begin
      if (look_r) begin
        look_r <= 1'b0;
        if (rd_cell) stop_r <= 1'b1;
      end else if (!stop_r) begin
        if (border) stop_r <= 1'b1;
        else look_r <= 1'b1;
      end
    end
  end

  assign sts.stop = cmd.step && ((look_r && rd_cell) || (!look_r && !stop_r && border));
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= pos_x;
      py_r   <= pos_y;
      mcos_r <= ray_cos[15] ? 17'(-{ray_cos[15], ray_cos}) : {1'b0, ray_cos};
      msin_r <= ray_sin[15] ? 17'(-{ray_sin[15], ray_sin}) : {1'b0, ray_sin};
      negx_r <= ray_cos[15];
      negy_r <= ray_sin[15];
      corr_r <= view_correction;
      mx_r   <= pos_x[15:10];
      my_r   <= pos_y[15:10];
    end
    if (cmd.store_dx) dx_r <= (mcos_r == '0) ? DistMax : div_q;
    if (cmd.store_dy) dy_r <= (msin_r == '0) ? DistMax : div_q;
    if (cmd.init_side) begin
      sx_r <= (fpx[42:32] != '0) ? DistMax : fpx[31:0];
      sy_r <= (fpy[42:32] != '0) ? DistMax : fpy[31:0];
    end
    if (cmd.step && !look_r && !stop_r) begin
      side_r <= !xstep;
      dist_r <= xstep ? sx_r : sy_r;
      if (!border) begin
        if (xstep) begin
          mx_r <= nmx;
          sx_r <= sadd_sat;
        end else begin
          my_r <= nmy;
          sy_r <= sadd_sat;
        end
      end
    end
    if (cmd.perp) perp_r <= perp_sat;
  end

  logic [HalfW-1:0] half;
  logic [10:0]      mid;
  logic signed [22:0] top, bot;
  logic [9:0]  top_o;
  logic [10:0] bot_o;
  always_comb begin
    half = (perp_r == '0 || div_q > 32'(HalfMax)) ? HalfMax : div_q[HalfW-1:0];
    mid  = screen_height >> 1;
    top  = $signed({12'd0, mid}) - $signed({2'b00, half});
    bot  = $signed({12'd0, mid}) + $signed({2'b00, half});
    top_o = top[22] ? 10'd0 : top[9:0];
    bot_o = (bot >= $signed({12'd0, screen_height})) ? screen_height : bot[10:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) result <= {5'd0, bot_o, top_o, perp_r, side_r, my_r, mx_r};
  end

endmodule

[src/ddarc_checker.sv]
// ddarc_checker: port-level assertions for the ray caster, bound to the top
// depends on ddarc_pkg
module ddarc_checker
  import ddarc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown(out_tdata)) else $error("unknown result data");

  a_ray_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid) else $error("result too early");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

bind dda_grid_ray_caster ddarc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

[sim/dda_grid_ray_caster_tb.sv]
// dda_grid_ray_caster_tb: self-checking testbench for the grid ray caster
// predicts hit cell, side, distance and wall rows of each ray request
// depends on ddarc_pkg and dda_grid_ray_caster
`timescale 1ns / 1ps

module dda_grid_ray_caster_tb;
  import ddarc_pkg::*;

  typedef struct {
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        hit_side;
    logic [16:0] perp;
    logic [9:0]  top;
    logic [10:0] bottom;
  } hit_t;

  localparam longint unsigned DMAX = 64'hFFFF_FFFF;

  class ray_scoreboard;
    bit wall[MapN*MapN];
    longint unsigned scr_h;
    longint unsigned scale;
    hit_t pending[$];
    int errors;

    function new();
      foreach (wall[i]) wall[i] = 0;
      scr_h = 512;
      scale = 640;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [10:0] val);
      if (idx == RegScreenHeight) scr_h = val;
      else if (idx == RegWallScale) scale = val;
    endfunction

    function longint unsigned recip(longint t);
      longint unsigned m;
      m = (t < 0) ? -t : t;
      if (m == 0) return DMAX;
      return (64'd1 << (14 + FracBits)) / m;
    endfunction

    function longint unsigned first_side(longint unsigned fr, bit neg, longint unsigned d);
      longint unsigned f, v;
      f = neg ? fr : ((64'd1 << FracBits) - fr);
      v = (f * d) >> FracBits;
      return (v > DMAX) ? DMAX : v;
    endfunction

    function void note_request(logic [InDataW-1:0] d);
      logic [5:0] mx, my;
      longint cs, sn;
      longint unsigned dx, dy, sx, sy, ray_dist, perp, h;
      longint half, mid, top, bot;
      bit negx, negy, side;
      hit_t r;
      if (d[0] == 1'b0) begin
        wall[{d[12:7], d[6:1]}] = d[13];
        return;
      end
      mx = d[29:24];
      my = d[45:40];
      cs = longint'($signed(d[61:46]));
      sn = longint'($signed(d[77:62]));
      negx = cs < 0;
      negy = sn < 0;
      dx = recip(cs);
      dy = recip(sn);
      sx = first_side(d[23:14], negx, dx);
      sy = first_side(d[39:30], negy, dy);
      side = 0;
      ray_dist = 0;
      for (int k = 0; k < 2 * MapN + 2; k++) begin
        if (sx < sy) begin
          side = 0;
          ray_dist = sx;
          if (negx ? mx == 0 : mx == MapMask) break;
          mx = negx ? mx - 6'd1 : mx + 6'd1;
          sx = (sx + dx > DMAX) ? DMAX : sx + dx;
        end else begin
          side = 1;
          ray_dist = sy;
          if (negy ? my == 0 : my == MapMask) break;
          my = negy ? my - 6'd1 : my + 6'd1;
          sy = (sy + dy > DMAX) ? DMAX : sy + dy;
        end
        if (wall[{my, mx}]) break;
      end
      perp = (ray_dist * longint'(d[92:78])) >> 14;
      if (perp > 131071) perp = 131071;
      if (perp == 0) begin
        half = 1 << 20;
      end else begin
        h = (scale << FracBits) / (2 * perp);
        half = (h > (1 << 20)) ? (1 << 20) : longint'(h);
      end
      mid = longint'(scr_h / 2);
      top = mid - half;
      bot = mid + half;
      if (top < 0) top = 0;
      if (bot >= longint'(scr_h)) bot = longint'(scr_h);
      r.hit_x = mx;
      r.hit_y = my;
      r.hit_side = side;
      r.perp = perp[16:0];
      r.top = top[9:0];
      r.bottom = bot[10:0];
      pending.push_back(r);
    endfunction

    function void check_hit(logic [OutDataW-1:0] d);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[5:0] !== e.hit_x) begin
        $display("%0t hit_x exp %0d got %0d", $realtime, e.hit_x, d[5:0]);
        errors++;
      end
      if (d[11:6] !== e.hit_y) begin
        $display("%0t hit_y exp %0d got %0d", $realtime, e.hit_y, d[11:6]);
        errors++;
      end
      if (d[12] !== e.hit_side) begin
        $display("%0t hit_side exp %0d got %0d", $realtime, e.hit_side, d[12]);
        errors++;
      end
      if (d[29:13] !== e.perp) begin
        $display("%0t perp_distance exp %0d got %0d", $realtime, e.perp, d[29:13]);
        errors++;
      end
      if (d[39:30] !== e.top) begin
        $display("%0t wall_top exp %0d got %0d", $realtime, e.top, d[39:30]);
        errors++;
      end
      if (d[50:40] !== e.bottom) begin
        $display("%0t wall_bottom exp %0d got %0d", $realtime, e.bottom, d[50:40]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [InDataW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [10:0] cfg_data;

  ray_scoreboard sb;
  bit calm;

  dda_grid_ray_caster dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_hit(out_tdata);
  end

  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_request(logic [InDataW-1:0] d);
    int n;
    n = calm ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(d);
  endtask

  task automatic write_cell(logic [5:0] x, logic [5:0] y, logic s);
    logic [InDataW-1:0] d;
    d = '0;
    d[6:1] = x;
    d[12:7] = y;
    d[13] = s;
    d[29:14] = $urandom;
    d[45:30] = $urandom;
    d[77:46] = $urandom;
    d[92:78] = $urandom;
    send_request(d);
  endtask

  task automatic cast_ray(logic [15:0] px, logic [15:0] py, logic [15:0] cs,
                          logic [15:0] sn, logic [14:0] corr);
    logic [InDataW-1:0] d;
    d = '0;
    d[0] = 1'b1;
    d[13:1] = $urandom;
    d[29:14] = px;
    d[45:30] = py;
    d[61:46] = cs;
    d[77:62] = sn;
    d[92:78] = corr;
    send_request(d);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd16384;
      2: return -16'sd16384;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  initial begin
    logic [10:0] sh, ws;
    int stop_pct;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = RegScreenHeight;
    cfg_data = '0;
    calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, border hits, zero trig, extremes
    cast_ray(16'd0, 16'd0, 16'd16384, 16'd0, 15'd16384);
    cast_ray(16'hFFFF, 16'hFFFF, -16'sd16384, 16'd0, 15'd16384);
    cast_ray(16'd0, 16'd0, 16'd0, 16'd0, 15'd16384);
    cast_ray(16'h8200, 16'h8200, 16'd0, -16'sd16384, 15'd0);
    cast_ray(16'h8000, 16'h8000, 16'd11585, 16'd11585, 15'd16384);
    cast_ray(16'h0000, 16'hFFFF, -16'sd1, 16'd1, 15'd1);
    write_cell(6'd33, 6'd32, 1'b1);
    write_cell(6'd32, 6'd33, 1'b1);
    write_cell(6'd63, 6'd63, 1'b1);
    cast_ray(16'h8000, 16'h8000, 16'd16384, 16'd0, 15'd16384);
    cast_ray(16'h8000, 16'h8000, 16'd0, 16'd16384, 15'd12000);
    cast_ray(16'h8400, 16'h8400, 16'd0, 16'd0, 15'd16384);
    cast_ray(16'h0000, 16'h0000, 16'd0, 16'd0, 15'd16384);
    cast_ray(16'hF800, 16'hF800, 16'd16384, 16'd16384, 15'd16384);
    write_cell(6'd33, 6'd32, 1'b0);
    cast_ray(16'h8000, 16'h8000, 16'd16384, 16'd0, 15'd16384);
    write_cell(6'd32, 6'd33, 1'b0);
    write_cell(6'd63, 6'd63, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin sh = 11'd1; ws = 11'd1; end
        1: begin sh = 11'd1024; ws = 11'd1024; end
        2: begin sh = 11'd512; ws = 11'd640; end
        default: begin sh = $urandom_range(1, 1024); ws = $urandom_range(1, 1024); end
      endcase
      write_reg(RegScreenHeight, sh);
      write_reg(RegWallScale, ws);
      calm = (ph == 2);
      stop_pct = 10 + 15 * ph;
      for (int i = 0; i < 320; i++) begin
        if (i == 160 && ph == 4) begin
          in_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 40)
          write_cell($urandom, $urandom, $urandom_range(0, 99) < stop_pct);
        else
          cast_ray($urandom, $urandom, rand_trig(), rand_trig(),
                   ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 16384))
                                               : 15'($urandom_range(12000, 16384)));
      end
    end
    calm = 0;
    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

endmodule
